// ----- sv/gbe_pkg.sv -----
package gbe_pkg;

  // Request codes as they arrive on req_type
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_LEFT   = 3'd1;
  localparam logic [2:0] REQ_RIGHT  = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // Fixed field widths
  localparam int CHAR_W = 8;
  localparam int POS_W  = 10;
  localparam int CNT_W  = 11;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_LEFT,
    OP_RIGHT,
    OP_DELETE,
    OP_READ,
    OP_NOP
  } op_t;

  // One queued command
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
  } cmd_t;

  // Queue handshake towards the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_if_t;

endpackage

// ----- sv/gbe_front.sv -----
module gbe_front import gbe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2:0]               req_type,
  input  logic [CHAR_W-1:0]        char_in,
  input  logic [POS_W-1:0]         read_pos,
  output logic                     busy,
  output cmd_if_t                  head,
  input  logic                     pop
);

  // Two-entry command queue
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  cmd_t       cmd_in;

  // Decode the request into an operation class
  always_comb begin
    cmd_in.ch  = char_in;
    cmd_in.pos = read_pos;
    unique case (req_type)
      REQ_INSERT: cmd_in.op = OP_INSERT;
      REQ_LEFT:   cmd_in.op = OP_LEFT;
      REQ_RIGHT:  cmd_in.op = OP_RIGHT;
      REQ_DELETE: cmd_in.op = OP_DELETE;
      REQ_READ:   cmd_in.op = OP_READ;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign busy = (cnt == 2'd2);
  assign push = start && !busy;
  assign head = {(cnt != 2'd0), q[rd_ptr]};

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // A transfer into the queue always leaves it non-empty
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push |=> (cnt != 2'd0))
    else $error("queue empty after a transfer in");

  // The back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

// ----- sv/gbe_back.sv -----
module gbe_back import gbe_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_if_t           head,
  output logic              pop,
  output logic              done,
  output logic [CHAR_W-1:0] char_out,
  output logic              read_valid,
  output logic [CNT_W-1:0]  text_length,
  output logic [CNT_W-1:0]  cursor_pos,
  output logic              overflow
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_READ
  } state_t;

  state_t            state;
  logic [CW-1:0]     left;
  logic [CW-1:0]     right;
  logic              move_to_right;
  logic [AW-1:0]     move_dst;

  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] mem_wdata;

  logic [CW-1:0]     used;
  logic              full;
  logic [CW-1:0]     left_m1;
  logic [CW-1:0]     gap_top;
  logic [CW-1:0]     right_first;
  logic [PW-1:0]     pos_w;
  logic              rd_lo;
  logic              rd_hi;
  logic [PW-1:0]     rd_idx;
  cmd_t              cmd;

  // Fit a count into the fixed result width
  function automatic logic [CNT_W-1:0] fit(input logic [CW-1:0] v);
    logic [CW+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, v};
    return w[CNT_W-1:0];
  endfunction

  // Gap arithmetic
  assign cmd         = head.cmd;
  assign used        = left + right;
  assign full        = (used == CW'(CAPACITY));
  assign left_m1     = left - CW'(1);
  assign gap_top     = CW'(CAPACITY) - right - CW'(1);
  assign right_first = CW'(CAPACITY) - right;
  assign pos_w       = PW'(cmd.pos);
  assign rd_lo       = pos_w < PW'(left);
  assign rd_hi       = pos_w < PW'(used);
  assign rd_idx      = PW'(CAPACITY) - PW'(right) + pos_w - PW'(left);
  assign pop         = (state == S_IDLE) && head.valid;

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = left[AW-1:0];
    mem_wdata = cmd.ch;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          case (cmd.op)
            OP_INSERT: mem_we = !full;
            OP_LEFT:   mem_addr = left_m1[AW-1:0];
            OP_RIGHT:  mem_addr = right_first[AW-1:0];
            OP_READ:   mem_addr = rd_lo ? pos_w[AW-1:0] : rd_idx[AW-1:0];
            default:   mem_we = 1'b0;
          endcase
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_addr  = move_dst;
        mem_wdata = mem_rdata;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Single-port text memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // Sequencer, counts and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      left          <= '0;
      right         <= '0;
      done          <= 1'b0;
      move_to_right <= 1'b0;
      move_dst      <= '0;
      char_out      <= '0;
      read_valid    <= 1'b0;
      text_length   <= '0;
      cursor_pos    <= '0;
      overflow      <= 1'b0;
    end else begin
      done       <= 1'b0;
      char_out   <= '0;
      read_valid <= 1'b0;
      overflow   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            text_length <= fit(used);
            cursor_pos  <= fit(left);
            case (cmd.op)
              OP_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  overflow <= 1'b1;
                end else begin
                  left        <= left + CW'(1);
                  text_length <= fit(used + CW'(1));
                  cursor_pos  <= fit(left + CW'(1));
                end
              end
              OP_LEFT: begin
                if (left != '0) begin
                  move_to_right <= 1'b1;
                  move_dst      <= gap_top[AW-1:0];
                  state         <= S_MOVE;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_RIGHT: begin
                if (right != '0) begin
                  move_to_right <= 1'b0;
                  move_dst      <= left[AW-1:0];
                  state         <= S_MOVE;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_DELETE: begin
                done <= 1'b1;
                if (left != '0) begin
                  left        <= left_m1;
                  text_length <= fit(used - CW'(1));
                  cursor_pos  <= fit(left_m1);
                end
              end
              OP_READ: begin
                if (rd_hi) begin
                  state <= S_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_MOVE: begin
          // Second half of a move: the character lands across the gap
          done  <= 1'b1;
          state <= S_IDLE;
          if (move_to_right) begin
            left       <= left_m1;
            right      <= right + CW'(1);
            cursor_pos <= fit(left_m1);
          end else begin
            left       <= left + CW'(1);
            right      <= right - CW'(1);
            cursor_pos <= fit(left + CW'(1));
          end
        end
        S_READ: begin
          done       <= 1'b1;
          char_out   <= mem_rdata;
          read_valid <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Text never outgrows the store
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(left) + (CW + 1)'(right) <= (CW + 1)'(CAPACITY))
    else $error("gap buffer overrun");

  // A move or read step always follows a command taken in idle
  a_step_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE || state == S_READ) |-> $past(pop))
    else $error("second step without a command");

  // Text length is unchanged across a move
  a_move_keeps_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |=> (used == $past(used)))
    else $error("move changed text length");

endmodule

// ----- sv/gap_buffer_line_editor_top.sv -----
// Gap buffer line editor, one result per accepted request, marked by done.
// Insert, delete, edge-stopped moves, out-of-range reads and unknown requests
// give done straight from idle; moves and in-text reads pass through S_MOVE or S_READ first.
// Such a step holds the back end out of idle, as the text memory has one port and a registered
// read, so the queue is not popped meanwhile; busy rises when the 2-entry queue fills.
// Reset clears the counts, queue and sequencer; text memory contents are left as is.
module gap_buffer_line_editor_top import gbe_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        req_type,
  input  logic [CHAR_W-1:0] char_in,
  input  logic [POS_W-1:0]  read_pos,
  output logic              done,
  output logic [CHAR_W-1:0] char_out,
  output logic              read_valid,
  output logic [CNT_W-1:0]  text_length,
  output logic [CNT_W-1:0]  cursor_pos,
  output logic              overflow
);

  cmd_if_t head;
  logic    pop;

  // Request decode and queue
  gbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .char_in  (char_in),
    .read_pos (read_pos),
    .busy     (busy),
    .head     (head),
    .pop      (pop)
  );

  // Gap buffer execution
  gbe_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .char_out    (char_out),
    .read_valid  (read_valid),
    .text_length (text_length),
    .cursor_pos  (cursor_pos),
    .overflow    (overflow)
  );

endmodule
